// File: sv/rpba_pkg.sv
`timescale 1ns / 1ps

package rpba_pkg;

  localparam int ChanW   = 8;
  localparam int OpW     = 3;
  localparam int FactorW = 16;
  localparam int WeightW = 9;
  localparam int RootW   = 16;
  localparam int TabN    = 256;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_SCALE = 3'd3,
    OP_AVG   = 3'd4,
    OP_GAMMA = 3'd5,
    OP_LERP  = 3'd6
  } op_t;

  // Advance strobes for the two datapath stages inside a lane.
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  typedef logic [RootW-1:0] gamma_tab_t [TabN];

  // s(x) = round(65536 * sqrt(x / 255)), clipped to 65535.
  // Largest k with k == 0 or (2k - 1)^2 * 255 <= x * 2^34.
  function automatic gamma_tab_t gamma_table();
    gamma_tab_t     tab;
    longint unsigned lim;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    for (int x = 0; x < TabN; x++) begin
      lim = longint'(x) << 34;
      lo  = 0;
      hi  = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t   = 2 * mid - 1;
        if (t * t * 255 <= lim) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      if (lo > 65535) begin
        lo = 65535;
      end
      tab[x] = RootW'(lo);
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_ROOT = gamma_table();

endpackage

// File: sv/rpba_if.sv
`timescale 1ns / 1ps

interface rpba_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] a_red;
  logic [7:0] a_green;
  logic [7:0] a_blue;
  logic [7:0] b_red;
  logic [7:0] b_green;
  logic [7:0] b_blue;
  logic [15:0] scale_factor;
  logic [8:0]  blend_weight;

  modport source (
    output valid, op, a_red, a_green, a_blue, b_red, b_green, b_blue,
           scale_factor, blend_weight,
    input  ready
  );
  modport sink (
    input  valid, op, a_red, a_green, a_blue, b_red, b_green, b_blue,
           scale_factor, blend_weight,
    output ready
  );
endinterface

interface rpba_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

// File: sv/rpba_lane.sv
`timescale 1ns / 1ps

module rpba_lane
  import rpba_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [OpW-1:0]     op,
  input  logic [ChanW-1:0]   a,
  input  logic [ChanW-1:0]   b,
  input  logic [FactorW-1:0] scale_factor,
  input  logic [WeightW-1:0] blend_weight,
  output logic [ChanW-1:0]   result
);

  // stage 1 combinational
  logic [WeightW-1:0] w_sat;
  logic [ChanW:0]     sum_ab;
  logic [ChanW-1:0]   simple_res;
  logic [15:0]        p_ab_next;
  logic [23:0]        p_scale_next;
  logic [16:0]        p_lerp_next;
  logic [RootW:0]     root_sum;

  // stage 1 registers
  logic [OpW-1:0]   op1;
  logic [ChanW-1:0] simple1;
  logic [15:0]      p_ab;
  logic [23:0]      p_scale;
  logic [16:0]      p_lerp;
  logic [RootW-1:0] m1;

  // stage 2
  logic [15:0]      div_t;
  logic [ChanW-1:0] res2_next;
  logic [OpW-1:0]   op2;
  logic [ChanW-1:0] res2;
  logic [31:0]      mm;
  logic [39:0]      g40;

  always_comb begin
    w_sat  = (blend_weight > WeightW'(256)) ? WeightW'(256) : blend_weight;
    sum_ab = {1'b0, a} + {1'b0, b};
    unique case (op_t'(op))
      OP_ADD:  simple_res = sum_ab[ChanW] ? '1 : sum_ab[ChanW-1:0];
      OP_SUB:  simple_res = (a > b) ? (a - b) : '0;
      OP_AVG:  simple_res = sum_ab[ChanW:1];
      default: simple_res = '0;
    endcase
    p_ab_next    = 16'(a) * 16'(b);
    p_scale_next = 24'(a) * 24'(scale_factor);
    p_lerp_next  = 17'(a) * 17'(WeightW'(256) - w_sat) + 17'(b) * 17'(w_sat);
    root_sum     = {1'b0, GAMMA_ROOT[a]} + {1'b0, GAMMA_ROOT[b]};
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      op1     <= op;
      simple1 <= simple_res;
      p_ab    <= p_ab_next;
      p_scale <= p_scale_next;
      p_lerp  <= p_lerp_next;
      m1      <= root_sum[RootW:1];
    end
  end

  // floor(p / 255) for p <= 255*255
  assign div_t = p_ab + 16'd1 + {8'd0, p_ab[15:8]};

  always_comb begin
    unique case (op_t'(op1))
      OP_MUL:   res2_next = div_t[15:8];
      OP_SCALE: res2_next = (p_scale[23:16] != '0) ? '1 : p_scale[15:8];
      OP_LERP:  res2_next = p_lerp[15:8];
      default:  res2_next = simple1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      op2  <= op1;
      res2 <= res2_next;
      mm   <= 32'(m1) * 32'(m1);
    end
  end

  // 255 * m^2 >> 32 never exceeds 254, so no clamp
  assign g40    = {mm, 8'd0} - {8'd0, mm};
  assign result = (op_t'(op2) == OP_GAMMA) ? g40[39:32] : res2;

endmodule

// File: sv/rgb_pixel_blend_alu_unit.sv
`timescale 1ns / 1ps
// Each word passes lane stages s1 and s2, then the output register.
// Throughput: one pixel per cycle; the three stage valid bits collapse
// bubbles so a new word enters whenever any stage ahead has room.
// Each color channel runs in its own lane; the output stage merges them.
// Reset (rst, synchronous) clears the stage valid bits only.

module rgb_pixel_blend_alu_unit
  import rpba_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rpba_in_if.sink       pix_in,
  rpba_out_if.source    pix_out
);

  logic      v1;
  logic      v2;
  logic      v3;
  logic      adv1;
  logic      adv2;
  logic      adv3;
  stage_en_t en;

  logic [ChanW-1:0] lane_red;
  logic [ChanW-1:0] lane_green;
  logic [ChanW-1:0] lane_blue;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  assign adv3  = !v3 || pix_out.ready;
  assign adv2  = !v2 || adv3;
  assign adv1  = !v1 || adv2;
  assign en.s1 = adv1;
  assign en.s2 = adv2;

  assign pix_in.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= pix_in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  rpba_lane u_lane_red (
    .clk          (clk),
    .en           (en),
    .op           (pix_in.op),
    .a            (pix_in.a_red),
    .b            (pix_in.b_red),
    .scale_factor (pix_in.scale_factor),
    .blend_weight (pix_in.blend_weight),
    .result       (lane_red)
  );

  rpba_lane u_lane_green (
    .clk          (clk),
    .en           (en),
    .op           (pix_in.op),
    .a            (pix_in.a_green),
    .b            (pix_in.b_green),
    .scale_factor (pix_in.scale_factor),
    .blend_weight (pix_in.blend_weight),
    .result       (lane_green)
  );

  rpba_lane u_lane_blue (
    .clk          (clk),
    .en           (en),
    .op           (pix_in.op),
    .a            (pix_in.a_blue),
    .b            (pix_in.b_blue),
    .scale_factor (pix_in.scale_factor),
    .blend_weight (pix_in.blend_weight),
    .result       (lane_blue)
  );

  // merge lanes into the output word; hold while stalled
  always_ff @(posedge clk) begin
    if (adv3) begin
      red   <= lane_red;
      green <= lane_green;
      blue  <= lane_blue;
    end
  end

  assign pix_out.valid     = v3;
  assign pix_out.out_red   = red;
  assign pix_out.out_green = green;
  assign pix_out.out_blue  = blue;

endmodule

// File: sv/rpba_checker.sv
`timescale 1ns / 1ps

module rpba_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an empty output stage means the pipeline has room
  a_room_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

  // with no back pressure an accepted word reaches the output stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($past(in_acc, 3) && $past(out_ready, 2) && $past(out_ready, 1) &&
     !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)) |-> out_valid)
    else $error("word lost or late in pipeline");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(out_valid) && !$past(out_ready) && !$past(rst)) |->
      (out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("stalled output word changed");

endmodule

bind rgb_pixel_blend_alu_unit rpba_props u_rpba_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_red   (pix_out.out_red),
  .out_green (pix_out.out_green),
  .out_blue  (pix_out.out_blue)
);

// File: dv/rpba_checker.sv
`timescale 1ns / 1ps

module rpba_checker
  import rpba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rpba_in_if   pix_in,
  rpba_out_if  pix_out,
  output int   mismatches,
  output int   backlog
);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  rgb_t expected_pix[$];
  rgb_t want;
  rgb_t got;
  int   fails = 0;

  // Rounded 65536*sqrt(x/255): start from the real root, then settle on the
  // largest k with k == 0 or (2k-1)^2 * 255 <= x * 2^34.
  function automatic logic [RootW-1:0] sqrt_code(input logic [ChanW-1:0] x);
    longint unsigned lim;
    longint unsigned k;
    lim = 64'(x) << 34;
    k   = 64'($rtoi(65536.0 * $sqrt(x / 255.0) + 0.5));
    while (k > 0 && (2 * k - 1) * (2 * k - 1) * 255 > lim) begin
      k = k - 1;
    end
    while (k < 65536 && (2 * k + 1) * (2 * k + 1) * 255 <= lim) begin
      k = k + 1;
    end
    return (k > 65535) ? 16'hFFFF : k[RootW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] blend_chan(
    input logic [OpW-1:0]     op,
    input logic [ChanW-1:0]   a,
    input logic [ChanW-1:0]   b,
    input logic [FactorW-1:0] factor,
    input logic [WeightW-1:0] weight
  );
    int unsigned     sum;
    int unsigned     w;
    longint unsigned mid;
    case (op_t'(op))
      OP_ADD: begin
        sum = a + b;
        return (sum > 255) ? 8'hFF : sum[ChanW-1:0];
      end
      OP_SUB: begin
        return (a > b) ? ChanW'(a - b) : 8'h00;
      end
      OP_MUL: begin
        sum = a * b;
        return ChanW'(sum / 255);
      end
      OP_SCALE: begin
        sum = (a * factor) >> 8;
        return (sum > 255) ? 8'hFF : sum[ChanW-1:0];
      end
      OP_AVG: begin
        sum = (a + b) >> 1;
        return sum[ChanW-1:0];
      end
      OP_GAMMA: begin
        mid = (64'(sqrt_code(a)) + 64'(sqrt_code(b))) >> 1;
        mid = (mid * mid * 255) >> 32;
        return (mid > 255) ? 8'hFF : mid[ChanW-1:0];
      end
      OP_LERP: begin
        // clamp weights past one to one
        w   = (weight > 256) ? 256 : weight;
        sum = (a * (256 - w) + b * w) >> 8;
        return sum[ChanW-1:0];
      end
      default: begin
        return 8'h00;
      end
    endcase
  endfunction

  function automatic rgb_t blend_pixel(
    input logic [OpW-1:0]     op,
    input rgb_t               a,
    input rgb_t               b,
    input logic [FactorW-1:0] factor,
    input logic [WeightW-1:0] weight
  );
    rgb_t res;
    res.red   = blend_chan(op, a.red, b.red, factor, weight);
    res.green = blend_chan(op, a.green, b.green, factor, weight);
    res.blue  = blend_chan(op, a.blue, b.blue, factor, weight);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_pix.delete();
      backlog <= 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        expected_pix.push_back(blend_pixel(pix_in.op,
          {pix_in.a_red, pix_in.a_green, pix_in.a_blue},
          {pix_in.b_red, pix_in.b_green, pix_in.b_blue},
          pix_in.scale_factor, pix_in.blend_weight));
      end
      if (pix_out.valid && pix_out.ready) begin
        got = {pix_out.out_red, pix_out.out_green, pix_out.out_blue};
        if (expected_pix.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected output word: got %h %h %h",
                     got.red, got.green, got.blue);
          end
          fails = fails + 1;
        end else begin
          want = expected_pix.pop_front();
          if (want != got) begin
            if (fails < 10) begin
              $display("pixel mismatch: expected %h %h %h, got %h %h %h",
                       want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
            end
            fails = fails + 1;
          end
        end
      end
      backlog <= expected_pix.size();
    end
    mismatches <= fails;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rpba_pkg::*;

  localparam logic [OpW-1:0] OpUnused   = 3'd7;
  localparam int             CycleLimit = 200000;
  localparam int             PhaseWords = 580;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle = 0;
  int   snk_idle = 0;
  int   cycles = 0;
  int   mismatches;
  int   backlog;

  rpba_in_if  pix_in ();
  rpba_out_if pix_out ();

  rgb_pixel_blend_alu_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  rpba_checker chk (
    .clk        (clk),
    .rst        (rst),
    .pix_in     (pix_in),
    .pix_out    (pix_out),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    pix_out.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [ChanW-1:0] rnd_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  // Hold the word until it is taken.
  task automatic send_pix(
    input logic [OpW-1:0]     op,
    input logic [23:0]        a_pix,
    input logic [23:0]        b_pix,
    input logic [FactorW-1:0] factor,
    input logic [WeightW-1:0] weight
  );
    while ($urandom_range(99) < src_idle) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid        <= 1'b1;
    pix_in.op           <= op;
    {pix_in.a_red, pix_in.a_green, pix_in.a_blue} <= a_pix;
    {pix_in.b_red, pix_in.b_green, pix_in.b_blue} <= b_pix;
    pix_in.scale_factor <= factor;
    pix_in.blend_weight <= weight;
    @(posedge clk);
    while (!pix_in.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [OpW-1:0]     op;
    logic [FactorW-1:0] factor;
    logic [WeightW-1:0] weight;
    op     = ($urandom_range(15) < 14) ? OpW'($urandom_range(OP_LERP)) : OpUnused;
    factor = $urandom_range(1) ? FactorW'($urandom_range(65535))
                               : FactorW'($urandom_range(511));
    weight = ($urandom_range(3) == 0) ? WeightW'($urandom_range(511))
                                      : WeightW'($urandom_range(256));
    send_pix(op, {rnd_chan(), rnd_chan(), rnd_chan()},
             {rnd_chan(), rnd_chan(), rnd_chan()}, factor, weight);
  endtask

  // Drop valid and wait for every predicted word to come back.
  task automatic drain();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    pix_in.valid        = 1'b0;
    pix_in.op           = OP_ADD;
    pix_in.a_red        = '0;
    pix_in.a_green      = '0;
    pix_in.a_blue       = '0;
    pix_in.b_red        = '0;
    pix_in.b_green      = '0;
    pix_in.b_blue       = '0;
    pix_in.scale_factor = '0;
    pix_in.blend_weight = '0;
    pix_out.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pix(OP_ADD,   24'hFFFFFF, 24'hFFFFFF, 16'h0000, 9'd0);
    send_pix(OP_ADD,   24'h000000, 24'h000000, 16'h0000, 9'd0);
    send_pix(OP_ADD,   24'h8001FF, 24'h80FE00, 16'h0000, 9'd0);
    send_pix(OP_SUB,   24'h000000, 24'hFFFFFF, 16'h0000, 9'd0);
    send_pix(OP_SUB,   24'hFFFFFF, 24'h000000, 16'h0000, 9'd0);
    send_pix(OP_SUB,   24'h1080FF, 24'h208001, 16'h0000, 9'd0);
    send_pix(OP_MUL,   24'hFFFFFF, 24'hFFFFFF, 16'h0000, 9'd0);
    send_pix(OP_MUL,   24'h0080FF, 24'hFF8001, 16'h0000, 9'd0);
    send_pix(OP_SCALE, 24'hFFFFFF, 24'h000000, 16'h0000, 9'd0);
    send_pix(OP_SCALE, 24'hFF0180, 24'h000000, 16'hFFFF, 9'd0);
    send_pix(OP_SCALE, 24'hFFAA55, 24'h000000, 16'h0100, 9'd0);
    send_pix(OP_SCALE, 24'hFFAA55, 24'h000000, 16'h0180, 9'd0);
    send_pix(OP_AVG,   24'hFFFFFF, 24'hFFFFFF, 16'h0000, 9'd0);
    send_pix(OP_AVG,   24'h0100FF, 24'h0001FE, 16'h0000, 9'd0);
    send_pix(OP_GAMMA, 24'h000000, 24'h000000, 16'h0000, 9'd0);
    send_pix(OP_GAMMA, 24'hFFFFFF, 24'hFFFFFF, 16'h0000, 9'd0);
    send_pix(OP_GAMMA, 24'h00FF01, 24'hFF0002, 16'h0000, 9'd0);
    send_pix(OP_LERP,  24'hFF00A0, 24'h00FF20, 16'h0000, 9'd0);
    send_pix(OP_LERP,  24'hFF00A0, 24'h00FF20, 16'h0000, 9'd256);
    send_pix(OP_LERP,  24'hFF00A0, 24'h00FF21, 16'h0000, 9'd128);
    send_pix(OP_LERP,  24'hFF00A0, 24'h00FF20, 16'h0000, 9'd257);
    send_pix(OP_LERP,  24'hFF00A0, 24'h00FF20, 16'h0000, 9'd511);
    send_pix(OpUnused, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 9'd511);
    send_pix(OpUnused, 24'h000000, 24'h000000, 16'h0000, 9'd0);
    drain();

    src_idle = 8;
    snk_idle = 74;
    repeat (PhaseWords) send_random();
    src_idle = 74;
    snk_idle = 8;
    repeat (PhaseWords) send_random();
    src_idle = 0;
    snk_idle = 0;
    repeat (PhaseWords) send_random();

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
